[hdl/assert_macros.svh]
// Assertion macros of the ring renderer modules.
// Included by every file that carries concurrent assertions; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define GRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true at a clock edge outside reset.
`define GRR_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define GRR_ASSERT(lbl, clk, rst_n, prop)
`define GRR_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hdl/grr_pkg.sv]
// Shared types and constants of the ring renderer.
// Used by the channel interfaces, the controller, the datapath and the top level.
package grr_pkg;

    // Field widths of the channels and the register port.
    localparam int CMD_W      = 2;
    localparam int KEY_W      = 4;
    localparam int PIX_IDX_W  = 4;
    localparam int CHAN_W     = 8;
    localparam int HUE_W      = 9;
    localparam int BRIGHT_W   = 8;
    localparam int RADIUS_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Color constants.
    localparam int CHAN_MAX       = 255;
    localparam int HUE_SECTOR_DEG = 60;
    localparam int HUE_SECTORS    = 8;

    // Commands carried by an input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_PRESS = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE    = 1'd0,
        CFG_BRIGHT = 1'd1
    } t_cfg_idx;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_BLACK,
        S_HUE0,
        S_HUE1,
        S_SQ,
        S_RINIT,
        S_ROOT,
        S_DIST,
        S_LVL0,
        S_LVL1,
        S_LVL2,
        S_CHMUL,
        S_EMIT
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_HUE0,
        OP_HUE1,
        OP_SQ,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_DIST,
        OP_LVL0,
        OP_LVL1,
        OP_LVL2,
        OP_CHMUL,
        OP_LOAD_PIX,
        OP_LOAD_BLACK
    } t_dp_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        t_dp_op op;
        logic   load_origin;
        logic   clr_radius;
        logic   adv_radius;
        logic   pix_first;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_ok;
        logic radius_done;
        logic last_pix;
        logic out_busy;
        logic root_done;
    } t_dp_stat;

endpackage

[hdl/grr_in_if.sv]
// Input channel of the ring renderer: command and key number with valid/ready.
// Depends on grr_pkg for the field widths.
interface grr_in_if import grr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key_num;

    modport source (output valid, output cmd, output key_num, input ready);
    modport sink (input valid, input cmd, input key_num, output ready);
endinterface

[hdl/grr_out_if.sv]
// Output channel of the ring renderer: one pixel color per word with valid/ready.
// Depends on grr_pkg for the field widths.
interface grr_out_if import grr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic                 last_pixel;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input red, input green,
                  input blue, input last_pixel, output ready);
endinterface

[hdl/grr_ctrl.sv]
// Controller of the ring renderer: command decode, ring state and step sequencing.
// Depends on grr_pkg and assert_macros.svh; drives grr_dp through t_dp_cmd.
`include "assert_macros.svh"
module grr_ctrl import grr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    t_state r_state, n_state;
    logic   r_armed, n_armed;
    logic   r_lit, n_lit;

    // State and ring flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_armed <= 1'b0;
            r_lit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_armed <= n_armed;
            r_lit   <= n_lit;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_armed    = r_armed;
        n_lit      = r_lit;
        o_cmd      = '0;
        o_cmd.op   = OP_NONE;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd'(i_in_cmd))
                        CMD_PRESS: begin
                            if (i_stat.key_ok) begin
                                o_cmd.load_origin = 1'b1;
                                o_cmd.clr_radius  = 1'b1;
                                n_armed           = 1'b1;
                                n_lit             = 1'b0;
                            end
                        end
                        CMD_CLEAR: begin
                            o_cmd.clr_radius = 1'b1;
                            o_cmd.pix_first  = 1'b1;
                            n_armed          = 1'b0;
                            n_lit            = 1'b0;
                            n_state          = S_BLACK;
                        end
                        CMD_TICK: begin
                            if (!r_armed || i_stat.radius_done) begin
                                if (r_lit) begin
                                    n_lit           = 1'b0;
                                    o_cmd.pix_first = 1'b1;
                                    n_state         = S_BLACK;
                                end
                            end else begin
                                o_cmd.pix_first = 1'b1;
                                n_state         = S_HUE0;
                            end
                        end
                        CMD_NONE: begin
                        end
                    endcase
                end
            end
            S_BLACK: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_LOAD_BLACK;
                    if (i_stat.last_pix) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HUE0: begin
                o_cmd.op = OP_HUE0;
                n_state  = S_HUE1;
            end
            S_HUE1: begin
                o_cmd.op = OP_HUE1;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_RINIT;
            end
            S_RINIT: begin
                o_cmd.op = OP_ROOT_INIT;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT_STEP;
                if (i_stat.root_done) begin
                    n_state = S_DIST;
                end
            end
            S_DIST: begin
                o_cmd.op = OP_DIST;
                n_state  = S_LVL0;
            end
            S_LVL0: begin
                o_cmd.op = OP_LVL0;
                n_state  = S_LVL1;
            end
            S_LVL1: begin
                o_cmd.op = OP_LVL1;
                n_state  = S_LVL2;
            end
            S_LVL2: begin
                o_cmd.op = OP_LVL2;
                n_state  = S_CHMUL;
            end
            S_CHMUL: begin
                o_cmd.op = OP_CHMUL;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_LOAD_PIX;
                    if (i_stat.last_pix) begin
                        o_cmd.adv_radius = 1'b1;
                        n_lit            = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_SQ;
                    end
                end
            end
        endcase
    end

    // The strip is marked lit only by the last word of a drawn frame.
    `GRR_ASSERT(a_lit_after_frame, i_clk, i_rst_n, $rose(r_lit) |-> $past(r_state == S_EMIT))
    // A ring is armed only by an accepted key press.
    `GRR_ASSERT(a_arm_by_press, i_clk, i_rst_n,
        $rose(r_armed) |-> $past(i_in_valid && (t_cmd'(i_in_cmd) == CMD_PRESS)))
    // The distance step follows a finished square root.
    `GRR_ASSERT(a_root_finished, i_clk, i_rst_n,
        (r_state == S_DIST) |-> $past((r_state == S_ROOT) && i_stat.root_done))
    // A black frame ends only after its last word was loaded.
    `GRR_ASSERT(a_black_complete, i_clk, i_rst_n,
        ((r_state == S_IDLE) && ($past(r_state) == S_BLACK)) |-> $past(i_stat.last_pix))

endmodule

[hdl/grr_isqrt.sv]
// Bit-serial integer square root, one result bit per step, rounding down.
// Stand-alone; used by grr_dp.
module grr_isqrt #(
    parameter int RT_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_step,
    input  logic [2*RT_W-1:0] i_value,
    output logic [RT_W-1:0]   o_root,
    output logic              o_done
);

    localparam int SQ_W  = 2 * RT_W;
    localparam int CNT_W = (RT_W > 1) ? $clog2(RT_W) : 1;

    logic [SQ_W-1:0]  r_v;
    logic [SQ_W-1:0]  r_res;
    logic [SQ_W-1:0]  r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  w_trial;

    assign w_trial = r_res + r_bit;

    // Step counter; the last step is the one taken while it reads zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(RT_W - 1);
        end else if (i_step && (r_cnt != '0)) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Remainder, partial root and the current trial bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_res <= '0;
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_step) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[RT_W-1:0];
    assign o_done = (r_cnt == '0);

endmodule

[hdl/grr_dp.sv]
// Datapath of the ring renderer: registers, ring state, hue, distance, level and output.
// Depends on grr_pkg and grr_isqrt; steered by grr_ctrl through t_dp_cmd.
module grr_dp import grr_pkg::*; #(
    parameter int PIXEL_COUNT       = 15,
    parameter int GRID_COLUMNS      = 5,
    parameter int SUB_UNITS_PER_KEY = 8,
    parameter int RING_HALF_WIDTH   = 6,
    parameter int END_RADIUS        = 41,
    parameter int FRONT_STEP        = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [KEY_W-1:0]      i_key,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PIX_IDX_W-1:0]  o_pixel_index,
    output logic [CHAN_W-1:0]     o_red,
    output logic [CHAN_W-1:0]     o_green,
    output logic [CHAN_W-1:0]     o_blue,
    output logic                  o_last_pixel
);

    localparam int ROWS     = (PIXEL_COUNT + GRID_COLUMNS - 1) / GRID_COLUMNS;
    localparam int COL_W    = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PIX_W    = $clog2(PIXEL_COUNT);
    localparam int SPAN     = ((GRID_COLUMNS > ROWS) ? GRID_COLUMNS : ROWS) * SUB_UNITS_PER_KEY;
    localparam int DIFF_W   = $clog2(SPAN);
    localparam int RT_W     = DIFF_W + 1;
    localparam int SQ_W     = 2 * RT_W;
    localparam int RING2    = RING_HALF_WIDTH * RING_HALF_WIDTH;
    localparam int RECIP    = (1 << 16) / RING2;
    localparam int REM_MUL  = (CHAN_MAX * 4) / HUE_SECTOR_DEG;
    localparam int CMP_W    = 12;

    // Configuration registers.
    logic [HUE_W-1:0]    r_hue;
    logic [BRIGHT_W-1:0] r_bright;

    // Ring state.
    logic [COL_W-1:0]    r_org_col;
    logic [ROW_W-1:0]    r_org_row;
    logic [RADIUS_W-1:0] r_radius;

    // Pixel position.
    logic [PIX_W-1:0] r_pix;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // Working registers.
    logic [3:0]          r_sector;
    logic [CHAN_W-1:0]   r_rem;
    logic [CHAN_W-1:0]   r_cr, r_cg, r_cb;
    logic [2*DIFF_W-1:0] r_dx2, r_dy2;
    logic                r_inband;
    logic [7:0]          r_dsq;
    logic [15:0]         r_num;
    logic [32:0]         r_prod;
    logic [CHAN_W-1:0]   r_lvl;
    logic [15:0]         r_pr, r_pg, r_pb;

    // Output word register.
    logic                 r_out_valid;
    logic [PIX_IDX_W-1:0] r_out_pix;
    logic [CHAN_W-1:0]    r_out_r, r_out_g, r_out_b;
    logic                 r_out_last;

    logic [KEY_W-1:0]    w_key_row;
    logic [COL_W-1:0]    w_key_col;
    logic [3:0]          w_sector;
    logic [5:0]          w_off;
    logic [CHAN_W-1:0]   w_a, w_b, w_q, w_t;
    logic [CHAN_W-1:0]   w_hr, w_hg, w_hb;
    logic [COL_W-1:0]    w_cdiff;
    logic [ROW_W-1:0]    w_rdiff;
    logic [DIFF_W-1:0]   w_adx, w_ady;
    logic [RT_W-1:0]     w_root;
    logic                w_root_done;
    logic [CMP_W-1:0]    w_dist, w_rad, w_dd;
    logic [8:0]          w_qest;
    logic [16:0]         w_rem17;
    logic [CHAN_W-1:0]   w_lvl;
    logic [6:0]          w_rad_sum;
    logic [7:0]          w_pix_ext;
    logic                w_load;
    logic                w_last;

    // Floor of x / 255 for any 16-bit x below 65280, where the quotient fits in 8 bits.
    function automatic logic [CHAN_W-1:0] f_div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(1) + 17'(x[15:8]);
        return s[15:8];
    endfunction

    // Origin row and column of the key: count row starts at or below the key.
    always_comb begin
        w_key_row = '0;
        for (int m = 1; m < 16; m++) begin
            if (int'(i_key) >= m * GRID_COLUMNS) begin
                w_key_row = w_key_row + KEY_W'(1);
            end
        end
        w_key_col = COL_W'(int'(i_key) - int'(w_key_row) * GRID_COLUMNS);
    end

    // Hue sector and the offset of the hue inside it.
    always_comb begin
        w_sector = '0;
        for (int m = 1; m <= HUE_SECTORS; m++) begin
            if (int'(r_hue) >= m * HUE_SECTOR_DEG) begin
                w_sector = w_sector + 4'(1);
            end
        end
        w_off = 6'(int'(r_hue) - int'(w_sector) * HUE_SECTOR_DEG);
    end

    // Falling and rising channel values of the sector and the sector select.
    always_comb begin
        w_a = 8'((16'(r_rem) * 16'(CHAN_MAX)) >> 8);
        w_b = 8'((16'(8'(CHAN_MAX) - r_rem) * 16'(CHAN_MAX)) >> 8);
        w_q = 8'((16'(8'(CHAN_MAX) - w_a) * 16'(CHAN_MAX)) >> 8);
        w_t = 8'((16'(8'(CHAN_MAX) - w_b) * 16'(CHAN_MAX)) >> 8);
        case (r_sector)
            4'd0: begin
                w_hr = 8'(CHAN_MAX); w_hg = w_t;           w_hb = '0;
            end
            4'd1: begin
                w_hr = w_q;           w_hg = 8'(CHAN_MAX); w_hb = '0;
            end
            4'd2: begin
                w_hr = '0;            w_hg = 8'(CHAN_MAX); w_hb = w_t;
            end
            4'd3: begin
                w_hr = '0;            w_hg = w_q;           w_hb = 8'(CHAN_MAX);
            end
            4'd4: begin
                w_hr = w_t;           w_hg = '0;            w_hb = 8'(CHAN_MAX);
            end
            default: begin
                w_hr = 8'(CHAN_MAX); w_hg = '0;            w_hb = w_q;
            end
        endcase
    end

    // Absolute offsets from the origin in sub-key units.
    always_comb begin
        w_cdiff = (r_col >= r_org_col) ? (r_col - r_org_col) : (r_org_col - r_col);
        w_rdiff = (r_row >= r_org_row) ? (r_row - r_org_row) : (r_org_row - r_row);
        w_adx   = DIFF_W'(int'(w_cdiff) * SUB_UNITS_PER_KEY);
        w_ady   = DIFF_W'(int'(w_rdiff) * SUB_UNITS_PER_KEY);
    end

    // Distance to the ring front.
    always_comb begin
        w_dist = CMP_W'(w_root);
        w_rad  = CMP_W'(r_radius);
        w_dd   = (w_dist >= w_rad) ? (w_dist - w_rad) : (w_rad - w_dist);
    end

    // Level division by the squared half width: reciprocal estimate, then one fix-up.
    always_comb begin
        w_qest  = r_prod[24:16];
        w_rem17 = 17'(r_num) - 17'(w_qest) * 17'(RING2);
        w_lvl   = (w_rem17 >= 17'(RING2)) ? 8'(w_qest + 9'(1)) : w_qest[7:0];
    end

    assign w_rad_sum = 7'(r_radius) + 7'(FRONT_STEP);
    assign w_load    = (i_cmd.op == OP_LOAD_PIX) || (i_cmd.op == OP_LOAD_BLACK);
    assign w_last    = (r_pix == PIX_W'(PIXEL_COUNT - 1));
    assign w_pix_ext = 8'(r_pix);

    grr_isqrt #(
        .RT_W (RT_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_ROOT_INIT),
        .i_step  (i_cmd.op == OP_ROOT_STEP),
        .i_value (SQ_W'(r_dx2) + SQ_W'(r_dy2)),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue    <= '0;
            r_bright <= BRIGHT_W'(CHAN_MAX);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HUE:    r_hue    <= i_cfg_data;
                CFG_BRIGHT: r_bright <= i_cfg_data[BRIGHT_W-1:0];
            endcase
        end
    end

    // Ring origin and front radius.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_col <= '0;
            r_org_row <= '0;
            r_radius  <= '0;
        end else begin
            if (i_cmd.load_origin) begin
                r_org_col <= w_key_col;
                r_org_row <= ROW_W'(w_key_row);
            end
            if (i_cmd.clr_radius) begin
                r_radius <= '0;
            end else if (i_cmd.adv_radius) begin
                r_radius <= (w_rad_sum > 7'((1 << RADIUS_W) - 1)) ?
                            RADIUS_W'((1 << RADIUS_W) - 1) : w_rad_sum[RADIUS_W-1:0];
            end
        end
    end

    // Pixel counter with its column and row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.pix_first) begin
            r_pix <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (w_load) begin
            r_pix <= r_pix + PIX_W'(1);
            if (r_col == COL_W'(GRID_COLUMNS - 1)) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Working registers, one step per operation.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_HUE0: begin
                r_sector <= w_sector;
                r_rem    <= 8'((int'(w_off) * REM_MUL) >> 2);
            end
            OP_HUE1: begin
                r_cr <= w_hr;
                r_cg <= w_hg;
                r_cb <= w_hb;
            end
            OP_SQ: begin
                r_dx2 <= (2*DIFF_W)'(w_adx) * (2*DIFF_W)'(w_adx);
                r_dy2 <= (2*DIFF_W)'(w_ady) * (2*DIFF_W)'(w_ady);
            end
            OP_DIST: begin
                r_inband <= (w_dd < CMP_W'(RING_HALF_WIDTH));
                r_dsq    <= 8'(w_dd[3:0]) * 8'(w_dd[3:0]);
            end
            OP_LVL0: begin
                r_num <= r_inband ? (16'(r_bright) * (16'(RING2) - 16'(r_dsq))) : '0;
            end
            OP_LVL1: begin
                r_prod <= 33'(r_num) * 33'(RECIP);
            end
            OP_LVL2: begin
                r_lvl <= w_lvl;
            end
            OP_CHMUL: begin
                r_pr <= 16'(r_cr) * 16'(r_lvl);
                r_pg <= 16'(r_cg) * 16'(r_lvl);
                r_pb <= 16'(r_cb) * 16'(r_lvl);
            end
            default: begin
            end
        endcase
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pix  <= w_pix_ext[PIX_IDX_W-1:0];
            r_out_last <= w_last;
            if (i_cmd.op == OP_LOAD_PIX) begin
                r_out_r <= f_div255(r_pr);
                r_out_g <= f_div255(r_pg);
                r_out_b <= f_div255(r_pb);
            end else begin
                r_out_r <= '0;
                r_out_g <= '0;
                r_out_b <= '0;
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.key_ok      = (CMP_W'(i_key) < CMP_W'(PIXEL_COUNT));
        o_stat.radius_done = (CMP_W'(r_radius) >= CMP_W'(END_RADIUS));
        o_stat.last_pix    = w_last;
        o_stat.out_busy    = r_out_valid && !i_out_ready;
        o_stat.root_done   = w_root_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_pix;
    assign o_red         = r_out_r;
    assign o_green       = r_out_g;
    assign o_blue        = r_out_b;
    assign o_last_pixel  = r_out_last;

endmodule

[hdl/grid_ripple_ring_renderer.sv]
// Ring renderer top level. A key press emits nothing. A drawn frame computes the hue once,
// then runs every pixel through squaring, the bit-serial square root, the distance, level
// and channel steps and the output load. A black frame loads one black word per pixel.
// One input word is worked on at a time; the last pixel word may wait in the output
// register while the next word is taken. Synchronous active-low reset clears the ring,
// the output valid flag and the controller, and loads hue 0 and brightness 255.
module grid_ripple_ring_renderer import grr_pkg::*; #(
    parameter int PIXEL_COUNT       = 15,
    parameter int GRID_COLUMNS      = 5,
    parameter int SUB_UNITS_PER_KEY = 8,
    parameter int RING_HALF_WIDTH   = 6,
    parameter int END_RADIUS        = 41,
    parameter int FRONT_STEP        = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    grr_in_if.sink                i_in,
    grr_out_if.source             o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    // Sequencer.
    grr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, ring state and output register.
    grr_dp #(
        .PIXEL_COUNT       (PIXEL_COUNT),
        .GRID_COLUMNS      (GRID_COLUMNS),
        .SUB_UNITS_PER_KEY (SUB_UNITS_PER_KEY),
        .RING_HALF_WIDTH   (RING_HALF_WIDTH),
        .END_RADIUS        (END_RADIUS),
        .FRONT_STEP        (FRONT_STEP)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_key         (i_in.key_num),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_pixel_index (o_out.pixel_index),
        .o_red         (o_out.red),
        .o_green       (o_out.green),
        .o_blue        (o_out.blue),
        .o_last_pixel  (o_out.last_pixel)
    );

    assign i_in.ready = w_in_ready;

endmodule
